// ----- rtl/rdsc_pkg.sv -----
// shared types, op codes and the digit-to-ascii helper for the radix converter
// no dependencies
package rdsc_pkg;

  localparam int VALUE_W = 32;
  localparam int DATA_W  = 40;   // widest digit word: ten bcd digits
  localparam int LEN_W   = 6;    // holds up to 40 characters
  localparam int ITER_W  = 5;    // 32 double-dabble steps
  localparam int BCD_DIGITS = 10;
  localparam int OCT_DIGITS = 11;
  localparam int HEX_DIGITS = 8;

  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_A    = 7'h41;

  typedef enum logic [1:0] {
    OP_BIN = 2'd0,
    OP_OCT = 2'd1,
    OP_HEX = 2'd2,
    OP_BCD = 2'd3
  } rdsc_op_t;

  // one string to emit: digits left aligned, first character at the top
  typedef struct packed {
    logic [DATA_W-1:0] data;
    rdsc_op_t          op;
    logic [LEN_W-1:0]  len;
    logic              neg;
  } rdsc_desc_t;

  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {3'b000, d};
    end else begin
      c = ASCII_A + {3'b000, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// ----- rtl/rdsc_if.sv -----
// valid/ready channel interfaces for the radix converter input and result items
// no dependencies
interface rdsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [1:0]  operation;

  modport source (output valid, output value, output operation, input ready);
  modport sink   (input valid, input value, input operation, output ready);
endinterface

interface rdsc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;
  logic       negative_rejected;

  modport source (output valid, output character, output last, output negative_rejected,
                  input ready);
  modport sink   (input valid, input character, input last, input negative_rejected,
                  output ready);
endinterface

// ----- rtl/radix_digit_string_converter_core.sv -----
// top level of the radix digit string converter: front, queue and back
// depends on rdsc_pkg, rdsc_if, rdsc_front, rdsc_fifo, rdsc_back
//
// usage
//   in_chan takes one item: a signed 32-bit value and a base code (binary,
//   octal, hex, bcd bit string). out_chan returns its ascii characters most
//   significant first, last high on the final one, negative_rejected high on
//   the single '0' given for a negative value outside binary mode.
// pacing
//   the front takes one item at a time: binary, zero and negative items go
//   straight to the queue; octal and hex first strip leading zero digits,
//   one per cycle, and bcd runs 32 double-dabble steps before stripping.
//   the back emits one character per cycle while the receiver takes them,
//   loading each string from the queue before its first character.
// reset and stalls
//   synchronous active-low reset empties the queue and drops any string in
//   flight. a stalled receiver holds the output register; the back stops,
//   the two-entry queue fills, and the front then holds in_chan.ready low.
module radix_digit_string_converter_core import rdsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rdsc_in_if.sink    in_chan,
  rdsc_out_if.source out_chan
);

  // front to queue
  logic       f_valid, f_ready;
  rdsc_desc_t f_desc;
  // queue to back
  logic       b_valid, b_ready;
  rdsc_desc_t b_desc;

  rdsc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_value     (in_chan.value),
    .in_operation (in_chan.operation),
    .desc_valid   (f_valid),
    .desc_ready   (f_ready),
    .desc         (f_desc)
  );

  // short descriptor queue so the front can classify the next item while a
  // string is still going out
  rdsc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_desc  (f_desc),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_desc  (b_desc)
  );

  // character emitter with its registered output stage
  rdsc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .desc_valid    (b_valid),
    .desc_ready    (b_ready),
    .desc          (b_desc),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_character (out_chan.character),
    .out_last      (out_chan.last),
    .out_neg       (out_chan.negative_rejected)
  );

endmodule

// ----- rtl/rdsc_front.sv -----
// front end: accepts an item, classifies it, runs double dabble for bcd and
// strips leading zero digits; depends on rdsc_pkg
module rdsc_front import rdsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  input  logic        [1:0]  in_operation,
  output logic               desc_valid,
  input  logic               desc_ready,
  output rdsc_desc_t         desc
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DABBLE = 4'b0010,
    ST_STRIP  = 4'b0100,
    ST_PUSH   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [DATA_W-1:0]   data_r, data_nxt;
  logic [VALUE_W-1:0]  bin_r, bin_nxt;
  rdsc_op_t            op_r, op_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic [DATA_W-1:0]   adj;
  logic                top_zero;
  rdsc_op_t            in_op;

  assign in_op    = rdsc_op_t'(in_operation);
  assign in_ready = (state_r == ST_IDLE);

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (data_r[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = data_r[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = data_r[4*k +: 4];
      end
    end
  end

  assign top_zero = (op_r == OP_OCT) ? (data_r[DATA_W-1 -: 3] == 3'd0)
                                     : (data_r[DATA_W-1 -: 4] == 4'd0);

  always_comb begin
    state_nxt = state_r;
    data_nxt  = data_r;
    bin_nxt   = bin_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_op;
          neg_nxt = 1'b0;
          if (in_op == OP_BIN) begin
            data_nxt  = {in_value, 8'd0};
            cnt_nxt   = LEN_W'(VALUE_W);
            state_nxt = ST_PUSH;
          end else if (in_value[31] || (in_value == 32'sd0)) begin
            // zero or a rejected negative: one '0'
            data_nxt  = '0;
            cnt_nxt   = LEN_W'(1);
            neg_nxt   = in_value[31];
            state_nxt = ST_PUSH;
          end else if (in_op == OP_OCT) begin
            data_nxt  = {1'b0, in_value, 7'd0};
            cnt_nxt   = LEN_W'(OCT_DIGITS);
            state_nxt = ST_STRIP;
          end else if (in_op == OP_HEX) begin
            data_nxt  = {in_value, 8'd0};
            cnt_nxt   = LEN_W'(HEX_DIGITS);
            state_nxt = ST_STRIP;
          end else begin
            data_nxt  = '0;
            bin_nxt   = in_value;
            iter_nxt  = '0;
            state_nxt = ST_DABBLE;
          end
        end
      end
      ST_DABBLE: begin
        data_nxt = {adj[DATA_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt  = {bin_r[VALUE_W-2:0], 1'b0};
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(VALUE_W - 1)) begin
          cnt_nxt   = LEN_W'(BCD_DIGITS);
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        // one leading zero digit per cycle; a positive value stops on a nonzero digit
        if (top_zero && (cnt_r != LEN_W'(1))) begin
          data_nxt = (op_r == OP_OCT) ? {data_r[DATA_W-4:0], 3'd0}
                                      : {data_r[DATA_W-5:0], 4'd0};
          cnt_nxt  = cnt_r - 1'b1;
        end else begin
          if (op_r == OP_BCD) begin
            cnt_nxt = {cnt_r[LEN_W-3:0], 2'b00};
          end
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (desc_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    bin_r  <= bin_nxt;
    op_r   <= op_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    iter_r <= iter_nxt;
  end

  assign desc_valid = (state_r == ST_PUSH);
  assign desc.data  = data_r;
  assign desc.op    = op_r;
  assign desc.len   = cnt_r;
  assign desc.neg   = neg_r;

endmodule

// ----- rtl/rdsc_fifo.sv -----
// two-entry queue of string descriptors between front and back
// depends on rdsc_pkg
module rdsc_fifo import rdsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  rdsc_desc_t wr_desc,
  output logic       rd_valid,
  input  logic       rd_ready,
  output rdsc_desc_t rd_desc
);

  rdsc_desc_t  entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        push, pop;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_desc  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

// ----- rtl/rdsc_back.sv -----
// back end: walks one descriptor into the output register a character per cycle
// while the receiver takes each one; depends on rdsc_pkg
module rdsc_back import rdsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       desc_valid,
  output logic       desc_ready,
  input  rdsc_desc_t desc,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_character,
  output logic       out_last,
  output logic       out_neg
);

  logic              busy_r, busy_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  rdsc_op_t          op_r;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              neg_r;
  logic              ovalid_r, ovalid_nxt;
  logic [6:0]        char_r, char_nxt;
  logic              last_r, last_nxt;
  logic              oneg_r, oneg_nxt;
  logic              advance, load;
  logic [3:0]        digit;

  assign advance    = busy_r && (!ovalid_r || out_ready);
  assign load       = !busy_r && desc_valid;
  assign desc_ready = !busy_r;

  always_comb begin
    unique case (op_r)
      OP_OCT: begin
        digit    = {1'b0, data_r[DATA_W-1 -: 3]};
        data_nxt = {data_r[DATA_W-4:0], 3'd0};
      end
      OP_HEX: begin
        digit    = data_r[DATA_W-1 -: 4];
        data_nxt = {data_r[DATA_W-5:0], 4'd0};
      end
      OP_BIN, OP_BCD: begin
        digit    = {3'd0, data_r[DATA_W-1]};
        data_nxt = {data_r[DATA_W-2:0], 1'b0};
      end
      default: begin
        digit    = 4'd0;
        data_nxt = data_r;
      end
    endcase
  end

  always_comb begin
    busy_nxt   = busy_r;
    rem_nxt    = rem_r;
    ovalid_nxt = ovalid_r;
    char_nxt   = char_r;
    last_nxt   = last_r;
    oneg_nxt   = oneg_r;
    if (advance) begin
      ovalid_nxt = 1'b1;
      char_nxt   = digit_to_ascii(digit);
      last_nxt   = (rem_r == LEN_W'(1));
      oneg_nxt   = neg_r;
      rem_nxt    = rem_r - 1'b1;
      busy_nxt   = (rem_r != LEN_W'(1));
    end else begin
      if (out_ready) begin
        ovalid_nxt = 1'b0;
      end
      if (load) begin
        busy_nxt = 1'b1;
        rem_nxt  = desc.len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    oneg_r <= oneg_nxt;
    if (load) begin
      data_r <= desc.data;
      op_r   <= desc.op;
      neg_r  <= desc.neg;
    end else if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid     = ovalid_r;
  assign out_character = char_r;
  assign out_last      = last_r;
  assign out_neg       = oneg_r;

endmodule
